// ----- sv/mjt_pkg.sv -----
// ----------------------------------------------------------------------------
// mjt_pkg
// Shared constants, types and reset values for the min-jerk trajectory block.
// ----------------------------------------------------------------------------
package mjt_pkg;

    localparam int JOINT_COUNT = 7;
    localparam int FRAC_BITS   = 16;
    localparam int ANGLE_W     = 19;
    localparam int DUR_W       = 26;
    localparam int TICK_W      = 16;

    localparam int CFG_IDX_W   = $clog2(JOINT_COUNT + 1);
    localparam int CFG_DATA_W  = (DUR_W > ANGLE_W) ? DUR_W : ANGLE_W;

    localparam int S_TDATA_W   = ((TICK_W + JOINT_COUNT * ANGLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((JOINT_COUNT * ANGLE_W + 7) / 8) * 8;

    // blend arithmetic widths
    localparam int S_W         = FRAC_BITS + 1;
    localparam int Q_W         = FRAC_BITS + 4;
    localparam int PROD_W      = FRAC_BITS + Q_W;
    localparam int DIFF_W      = ANGLE_W + 1;

    localparam logic [DUR_W-1:0] DURATION_RESET = DUR_W'(4000000);

    localparam logic [CFG_IDX_W-1:0] REG_DURATION    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = CFG_IDX_W'(1);

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BLEND,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        BL_IDLE,
        BL_SQ,
        BL_CUBE,
        BL_POLY,
        BL_SAT
    } blend_phase_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic done;
    } lane_ctrl_t;

    function automatic angle_t target_reset(input int idx);
        angle_t val;
        case (idx)
            1:       val = angle_t'(-32768);
            3:       val = angle_t'(-144179);
            5:       val = angle_t'(111411);
            6:       val = angle_t'(52429);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- sv/min_jerk_joint_trajectory_top.sv -----
// ----------------------------------------------------------------------------
// min_jerk_joint_trajectory_top
// Minimum-jerk move from the first measured pose to the home pose.
//
//  channel | dir | ports                       | contents
//  s_      | in  | s_tvalid s_tready s_tdata   | tick period, measured angles
//  m_      | out | m_tvalid m_tready m_tdata   | command angles, finished flag
//  cfg_    | in  | cfg_valid cfg_ready cfg_*   | duration, home angles
//
// an in-progress beat runs the divider first, which makes one
// quotient bit per cycle, then four blend steps on one multiplier, two lane steps
// a finished beat skips divider and blend and goes straight to the lane steps
// one beat at a time; the next beat is taken while a result waits on m_
// synchronous active-low reset, no clearing pass; cfg_ready is always high
// ----------------------------------------------------------------------------
module min_jerk_joint_trajectory_top
    import mjt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tick_period_us, measured_angle_0 .. measured_angle_6, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // command_angle_0 .. command_angle_6, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // move_finished
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_state_t state_reg, state_next;

    logic [DUR_W-1:0]     duration_reg;
    angle_t               target_reg [JOINT_COUNT];
    angle_t               start_reg  [JOINT_COUNT];
    logic [DUR_W-1:0]     elapsed_reg;
    logic                 start_latched_reg;
    logic                 done_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 accept;
    logic [TICK_W-1:0]    tick;
    angle_t               measured [JOINT_COUNT];
    logic [DUR_W:0]       elapsed_sum;
    logic                 done_now;
    logic [DUR_W-1:0]     elapsed_next;

    logic                 div_start;
    logic                 div_done;
    logic [FRAC_BITS-1:0] ratio;
    logic                 blend_done;
    logic [S_W-1:0]       blend_s;
    lane_ctrl_t           lane_ctrl;
    angle_t               lane_cmd [JOINT_COUNT];
    logic                 out_load;
    logic [M_TDATA_W-1:0] m_tdata_next;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign tick      = s_tdata[TICK_W-1:0];

    always_comb begin
        for (int i = 0; i < JOINT_COUNT; i++) begin
            measured[i] = s_tdata[TICK_W + i * ANGLE_W +: ANGLE_W];
        end
    end

    always_comb begin
        elapsed_sum  = (DUR_W + 1)'(elapsed_reg) + (DUR_W + 1)'(tick);
        done_now     = elapsed_sum >= {1'b0, duration_reg};
        elapsed_next = done_now ? duration_reg : elapsed_sum[DUR_W-1:0];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg <= DURATION_RESET;
            for (int i = 0; i < JOINT_COUNT; i++) begin
                target_reg[i] <= target_reset(i);
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_DURATION) begin
                duration_reg <= cfg_data[DUR_W-1:0];
            end
            for (int i = 0; i < JOINT_COUNT; i++) begin
                if (cfg_index == REG_TARGET_BASE + CFG_IDX_W'(i)) begin
                    target_reg[i] <= cfg_data[ANGLE_W-1:0];
                end
            end
        end
    end

    // tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg       <= '0;
            start_latched_reg <= 1'b0;
            done_reg          <= 1'b0;
        end else if (accept) begin
            elapsed_reg       <= elapsed_next;
            start_latched_reg <= 1'b1;
            done_reg          <= done_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !start_latched_reg) begin
            for (int i = 0; i < JOINT_COUNT; i++) begin
                start_reg[i] <= measured[i];
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = done_now ? ST_MUL : ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_BLEND;
            ST_BLEND: if (blend_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // controls
    always_comb begin
        s_tready         = 1'b0;
        div_start        = 1'b0;
        out_load         = 1'b0;
        lane_ctrl.mul_en = 1'b0;
        lane_ctrl.add_en = 1'b0;
        lane_ctrl.done   = done_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                div_start = s_tvalid && !done_now;
            end
            ST_MUL:  lane_ctrl.mul_en = 1'b1;
            ST_ADD:  lane_ctrl.add_en = 1'b1;
            ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    mjt_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (elapsed_next),
        .divisor  (duration_reg),
        .done     (div_done),
        .quotient (ratio)
    );

    mjt_blend u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_done),
        .r       (ratio),
        .done    (blend_done),
        .s       (blend_s)
    );

    for (genvar g = 0; g < JOINT_COUNT; g++) begin : g_lane
        mjt_lane u_lane (
            .aclk        (aclk),
            .ctrl        (lane_ctrl),
            .start_angle (start_reg[g]),
            .home_angle  (target_reg[g]),
            .s           (blend_s),
            .cmd         (lane_cmd[g])
        );
    end

    // merge lanes into the output beat
    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < JOINT_COUNT; i++) begin
            m_tdata_next[i * ANGLE_W +: ANGLE_W] = lane_cmd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- sv/mjt_divider.sv -----
// ----------------------------------------------------------------------------
// mjt_divider
// Restoring divider, one quotient bit per cycle: floor(elapsed * 2^F / dur).
// ----------------------------------------------------------------------------
module mjt_divider
    import mjt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DUR_W-1:0]     dividend,
    input  logic [DUR_W-1:0]     divisor,
    output logic                 done,
    output logic [FRAC_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DUR_W-1:0]     rem_reg;
    logic [FRAC_BITS-1:0] quot_reg;

    logic [DUR_W:0]       trial;
    logic                 fits;
    logic [DUR_W:0]       rem_step;

    always_comb begin
        trial    = {rem_reg, 1'b0};
        fits     = trial >= {1'b0, divisor};
        rem_step = fits ? (trial - {1'b0, divisor}) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_step[DUR_W-1:0];
            quot_reg <= {quot_reg[FRAC_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- sv/mjt_blend.sv -----
// ----------------------------------------------------------------------------
// mjt_blend
// Quintic blend s = r^3 * (10 - 15r + 6r^2) on one shared multiplier.
// ----------------------------------------------------------------------------
module mjt_blend
    import mjt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [FRAC_BITS-1:0] r,
    output logic                 done,
    output logic [S_W-1:0]       s
);

    localparam logic [Q_W:0]   Q_BASE = (Q_W + 1)'(10) << FRAC_BITS;
    localparam logic [Q_W-1:0] S_ONE  = Q_W'(1) << FRAC_BITS;

    blend_phase_t phase_reg, phase_next;

    logic [FRAC_BITS-1:0] r_reg;
    logic [Q_W-1:0]       q_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [S_W-1:0]       s_reg;
    logic                 done_reg;

    logic [FRAC_BITS-1:0] op_a;
    logic [Q_W-1:0]       op_b;
    logic                 mul_en;
    logic                 load_q;
    logic                 load_s;

    logic [FRAC_BITS-1:0] prod_hi;
    logic [Q_W:0]         q_sum;
    logic [Q_W-1:0]       s_raw;

    assign prod_hi = prod_reg[FRAC_BITS +: FRAC_BITS];
    assign s_raw   = prod_reg[PROD_W-1:FRAC_BITS];

    always_comb begin
        q_sum = Q_BASE + (Q_W + 1)'(prod_hi) * (Q_W + 1)'(6)
                - (Q_W + 1)'(r_reg) * (Q_W + 1)'(15);
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            BL_IDLE: if (start) phase_next = BL_SQ;
            BL_SQ:   phase_next = BL_CUBE;
            BL_CUBE: phase_next = BL_POLY;
            BL_POLY: phase_next = BL_SAT;
            BL_SAT:  phase_next = BL_IDLE;
            default: phase_next = BL_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        op_a   = r_reg;
        op_b   = Q_W'(r_reg);
        mul_en = 1'b0;
        load_q = 1'b0;
        load_s = 1'b0;
        case (phase_reg)
            BL_SQ: begin
                mul_en = 1'b1;
            end
            BL_CUBE: begin
                op_a   = prod_hi;
                mul_en = 1'b1;
                load_q = 1'b1;
            end
            BL_POLY: begin
                op_a   = prod_hi;
                op_b   = q_reg;
                mul_en = 1'b1;
            end
            BL_SAT: begin
                load_s = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= BL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= load_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) r_reg <= r;
        if (mul_en) prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        if (load_q) q_reg <= q_sum[Q_W-1:0];
        if (load_s) s_reg <= (s_raw > S_ONE) ? S_ONE[S_W-1:0] : s_raw[S_W-1:0];
    end

    assign done = done_reg;
    assign s    = s_reg;

endmodule

// ----- sv/mjt_lane.sv -----
// ----------------------------------------------------------------------------
// mjt_lane
// One joint: start + floor((home - start) * s / 2^F), or home once finished.
// ----------------------------------------------------------------------------
module mjt_lane
    import mjt_pkg::*;
(
    input  logic           aclk,
    input  lane_ctrl_t     ctrl,
    input  angle_t         start_angle,
    input  angle_t         home_angle,
    input  logic [S_W-1:0] s,
    output angle_t         cmd
);

    localparam int LP_W = DIFF_W + S_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [LP_W-1:0]   prod_reg;
    logic signed [LP_W-1:0]   shifted;
    logic signed [LP_W-1:0]   sum;
    angle_t                   cmd_reg;

    assign diff    = DIFF_W'(home_angle) - DIFF_W'(start_angle);
    assign shifted = prod_reg >>> FRAC_BITS;
    assign sum     = shifted + LP_W'(start_angle);

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) prod_reg <= LP_W'(diff) * LP_W'($signed({1'b0, s}));
        if (ctrl.add_en) cmd_reg <= ctrl.done ? home_angle : sum[ANGLE_W-1:0];
    end

    assign cmd = cmd_reg;

endmodule

// ----- sv/mjt_checker.sv -----
// ----------------------------------------------------------------------------
// mjt_checker
// Port-level checks on the min-jerk trajectory block, bound to the top level.
// ----------------------------------------------------------------------------
module mjt_checker
    import mjt_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tuser
);

    // one beat in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in work");

    // no result straight after reset
    a_quiet_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result beat right after reset");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

endmodule

bind min_jerk_joint_trajectory_top mjt_checker u_checker (.*);

// ----- test/tb_min_jerk_joint_trajectory_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_jerk_joint_trajectory_top
// Drives control ticks into the min-jerk trajectory block and checks every
// command beat against an in-bench model of the quintic blend toward home.
// Moves are reprogrammed between phases: short, long, lowered and zero
// durations and new home poses. Both stream sides idle at random, and one
// phase stalls the result side long enough to back up the tick side.
// ----------------------------------------------------------------------------
module tb_min_jerk_joint_trajectory_top;
    import mjt_pkg::*;

    localparam int RX_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_BEATS   = 550;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;
    localparam angle_t ANGLE_MAX = angle_t'((1 << (ANGLE_W - 1)) - 1);
    localparam angle_t ANGLE_MIN = angle_t'(-(1 << (ANGLE_W - 1)));

    typedef angle_t [JOINT_COUNT-1:0] pose_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        pose_t             angle;
    } tick_beat_t;

    typedef struct packed {
        pose_t cmd;
        logic  finished;
    } cmd_beat_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } idle_mode_t;

    localparam pose_t HOME_RESET = {
        angle_t'(52429), angle_t'(111411), angle_t'(0), angle_t'(-144179),
        angle_t'(0), angle_t'(-32768), angle_t'(0)
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // trajectory model state
    logic [DUR_W-1:0] move_dur = DURATION_RESET;
    pose_t            home_pose = HOME_RESET;
    logic [DUR_W-1:0] elapsed_acc = '0;
    pose_t            start_pose = '0;
    logic             start_taken = 1'b0;

    tick_beat_t tick_q[$];
    cmd_beat_t  cmd_expect_q[$];
    tick_beat_t tx_beat;
    int         beats_queued = 0;
    int         beats_taken  = 0;
    int         mismatch_cnt = 0;
    int         tx_wait = 0;
    int         rx_wait = 0;
    int         hold_left = 0;
    logic       hold_kick = 1'b0;
    idle_mode_t tx_idle_mode = IDLE_NONE;
    idle_mode_t rx_idle_mode = IDLE_NONE;

    min_jerk_joint_trajectory_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic cmd_beat_t advance_trajectory(input tick_beat_t beat);
        cmd_beat_t       res;
        logic [DUR_W:0]  sum;
        longint          one;
        longint          ratio;
        longint          r2;
        longint          r3;
        longint          poly;
        longint          blend_s;
        longint          diff;
        one = longint'(1) << FRAC_BITS;
        if (!start_taken) begin
            start_pose  = beat.angle;
            start_taken = 1'b1;
        end
        sum = {1'b0, elapsed_acc} + (DUR_W + 1)'(beat.tick);
        if (sum > {1'b0, move_dur})
            sum = {1'b0, move_dur};
        elapsed_acc  = sum[DUR_W-1:0];
        res.finished = (elapsed_acc >= move_dur);
        blend_s = 0;
        if (!res.finished) begin
            ratio   = (longint'(elapsed_acc) << FRAC_BITS) / longint'(move_dur);
            r2      = (ratio * ratio) >> FRAC_BITS;
            r3      = (r2 * ratio) >> FRAC_BITS;
            poly    = 10 * one + 6 * r2 - 15 * ratio;
            blend_s = (r3 * poly) >> FRAC_BITS;
            if (blend_s > one)
                blend_s = one;
        end
        for (int j = 0; j < JOINT_COUNT; j++) begin
            if (res.finished) begin
                res.cmd[j] = home_pose[j];
            end else begin
                diff = longint'($signed(home_pose[j])) - longint'($signed(start_pose[j]));
                res.cmd[j] = angle_t'(longint'($signed(start_pose[j]))
                                      + ((diff * blend_s) >>> FRAC_BITS));
            end
        end
        return res;
    endfunction

    function automatic int draw_gap(input idle_mode_t mode);
        case (mode)
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            IDLE_HEAVY: return $urandom_range(0, 18);
            default:    return 0;
        endcase
    endfunction

    function automatic angle_t pick_angle();
        case ($urandom_range(0, 7))
            0:       return ANGLE_MIN;
            1:       return ANGLE_MAX;
            default: return angle_t'($urandom);
        endcase
    endfunction

    function automatic pose_t pick_pose();
        pose_t p;
        for (int j = 0; j < JOINT_COUNT; j++)
            p[j] = pick_angle();
        return p;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    // tick side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                cmd_expect_q.push_back(advance_trajectory(tx_beat));
                beats_taken++;
                tx_wait = draw_gap(tx_idle_mode);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    tx_beat = tick_q.pop_front();
                    s_tdata  <= S_TDATA_W'({tx_beat.angle, tx_beat.tick});
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long result-side hold
    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= RX_HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // command side
    always @(posedge aclk) begin
        cmd_beat_t want;
        pose_t     got_cmd;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_cmd = m_tdata[JOINT_COUNT*ANGLE_W-1:0];
                if (cmd_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("command beat with no tick pending: %h", m_tdata);
                end else begin
                    want = cmd_expect_q.pop_front();
                    for (int j = 0; j < JOINT_COUNT; j++)
                        if (got_cmd[j] !== want.cmd[j])
                            report_mismatch($sformatf("command_angle_%0d", j),
                                            want.cmd[j], got_cmd[j]);
                    if (m_tuser !== want.finished)
                        report_mismatch("move_finished", want.finished, m_tuser);
                end
                rx_wait = draw_gap(rx_idle_mode);
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_tick(input logic [TICK_W-1:0] tick, input pose_t meas);
        tick_q.push_back('{tick, meas});
        beats_queued++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (beats_taken != beats_queued || cmd_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_valid high, caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
    endtask

    task automatic program_move(input logic [DUR_W-1:0] dur, input pose_t home);
        write_reg(REG_DURATION, CFG_DATA_W'(dur));
        move_dur = dur;
        for (int j = 0; j < JOINT_COUNT; j++) begin
            write_reg(REG_TARGET_BASE + CFG_IDX_W'(j), CFG_DATA_W'($signed(home[j])));
            home_pose[j] = home[j];
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        pose_t            corner_pose;
        pose_t            flip_pose;
        longint           span;
        longint           next_dur;
        logic [TICK_W-1:0] tick;
        int               phase;
        int               n_beats;
        for (int j = 0; j < JOINT_COUNT; j++) begin
            corner_pose[j] = (j % 2 == 0) ? ANGLE_MIN : ANGLE_MAX;
            flip_pose[j]   = (j % 2 == 0) ? ANGLE_MAX : ANGLE_MIN;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset move: start latched from corner pose, zero tick repeats
        queue_tick(16'd0, corner_pose);
        queue_tick(16'd0, pick_pose());
        queue_tick(16'hFFFF, flip_pose);
        queue_tick(16'hFFFF, pick_pose());
        queue_tick(16'hFFFF, pick_pose());
        queue_tick(16'd1, pick_pose());
        wait_idle();

        // full-swing move to the opposite corner, run past the end
        program_move(DUR_W'(longint'(elapsed_acc) + 300000), flip_pose);
        repeat (5) queue_tick(16'hFFFF, pick_pose());
        queue_tick(16'd0, pick_pose());
        queue_tick(16'd1, pick_pose());
        wait_idle();

        // duration lowered below elapsed time, then zero duration
        program_move(DUR_W'(1), pick_pose());
        queue_tick(16'd0, pick_pose());
        queue_tick(16'd1234, pick_pose());
        wait_idle();
        write_reg(REG_DURATION, '0);
        move_dur = '0;
        cfg_valid <= 1'b0;
        queue_tick(16'd77, pick_pose());
        wait_idle();

        // longest duration
        program_move(DUR_MAX, pick_pose());
        repeat (3) queue_tick(16'hFFFF, pick_pose());
        wait_idle();

        phase = 0;
        while (beats_queued < RANDOM_BEATS + 20) begin
            case ($urandom_range(0, 9))
                0: next_dur = (elapsed_acc > 1) ? $urandom_range(1, elapsed_acc - 1) : 1;
                1: next_dur = $urandom_range(1, DUR_MAX);
                default: begin
                    span = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 150000)
                                                        : $urandom_range(150000, 2000000);
                    next_dur = longint'(elapsed_acc) + span;
                    if (next_dur > longint'(DUR_MAX))
                        next_dur = DUR_MAX;
                end
            endcase
            program_move(DUR_W'(next_dur), pick_pose());
            tx_idle_mode = idle_mode_t'($urandom_range(0, 2));
            rx_idle_mode = idle_mode_t'($urandom_range(0, 2));
            n_beats = $urandom_range(8, 40);
            if (phase == 3) begin
                // back up the tick side behind a stalled result side
                tx_idle_mode = IDLE_NONE;
                rx_idle_mode = IDLE_LIGHT;
                n_beats = 30;
                hold_kick <= 1'b1;
                @(posedge aclk);
                hold_kick <= 1'b0;
            end
            for (int k = 0; k < n_beats; k++) begin
                case ($urandom_range(0, 15))
                    0:       tick = '0;
                    1:       tick = '1;
                    2, 3, 4: tick = TICK_W'($urandom);
                    default: tick = TICK_W'($urandom_range(1, 5000));
                endcase
                queue_tick(tick, pick_pose());
            end
            wait_idle();
            phase++;
        end

        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/mjt_pkg.sv
sv/mjt_divider.sv
sv/mjt_blend.sv
sv/mjt_lane.sv
sv/min_jerk_joint_trajectory_top.sv
sv/mjt_checker.sv
test/tb_min_jerk_joint_trajectory_top.sv
